@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the execute unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/mie_pkg.sv @@
// ----------------------------------------------------------------------------
// mie_pkg
// Widths, field positions and inter-module structs of the I-type execute unit.
// ----------------------------------------------------------------------------
package mie_pkg;

   localparam int MEM_BYTES = 65536;
   localparam int MEM_AW    = $clog2(MEM_BYTES);
   localparam int ROW_AW    = MEM_AW - 2;
   localparam int MEM_ROWS  = MEM_BYTES / 4;

   localparam int REG_AW    = 5;
   localparam int REG_COUNT = 32;
   localparam int RS_LSB    = 21;
   localparam int RT_LSB    = 16;

   typedef struct packed {
      logic              en;
      logic [REG_AW-1:0] idx;
      logic [31:0]       data;
   } rf_wr_type;

   typedef struct packed {
      logic                   en;
      logic [3:0]             we;
      logic [3:0][ROW_AW-1:0] row;
      logic [3:0][7:0]        wdata;
   } dmem_req_type;

endpackage

@@ rtl/core/mie_regfile.sv @@
// ----------------------------------------------------------------------------
// mie_regfile
// 32 x 32 register file, two registered read ports, one write port.
// Entries read as zero until first written after reset.
// ----------------------------------------------------------------------------
module mie_regfile
   import mie_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [REG_AW-1:0] rd_idx_a,
   input  logic [REG_AW-1:0] rd_idx_b,
   input  rf_wr_type         wr,
   output logic [31:0]       rd_data_a,
   output logic [31:0]       rd_data_b
);

   logic [31:0]          regs_ff [REG_COUNT];
   logic [REG_COUNT-1:0] valid_ff;
   logic [31:0]          rd_a_ff;
   logic [31:0]          rd_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         regs_ff[wr.idx] <= wr.data;
      end
      if (rd_en) begin
         rd_a_ff <= valid_ff[rd_idx_a] ? regs_ff[rd_idx_a] : '0;
         rd_b_ff <= valid_ff[rd_idx_b] ? regs_ff[rd_idx_b] : '0;
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ rtl/core/mie_dmem.sv @@
// ----------------------------------------------------------------------------
// mie_dmem
// Byte data memory as four byte-wide banks, one per address lane, so that an
// unaligned word touches each bank once. Registered read data.
// ----------------------------------------------------------------------------
module mie_dmem
   import mie_pkg::*;
(
   input  logic         clock,
   input  dmem_req_type req,
   output logic [7:0]   rd_data [4]
);

   for (genvar j = 0; j < 4; j++) begin : g_bank
      logic [7:0] bank_ff [MEM_ROWS];
      logic [7:0] q_ff;

      always_ff @(posedge clock) begin
         if (req.we[j]) begin
            bank_ff[req.row[j]] <= req.wdata[j];
         end
         if (req.en) begin
            q_ff <= bank_ff[req.row[j]];
         end
      end

      assign rd_data[j] = q_ff;
   end

endmodule

@@ rtl/core/mips_itype_execute_unit.sv @@
// ----------------------------------------------------------------------------
// mips_itype_execute_unit
// Executes one MIPS I-type instruction per transfer against a register file
// and a little-endian byte data memory.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  command, instruction_word, pc
//   rsp      out        rsp_valid/rsp_stall  register, memory, branch results
//
// Three registered stages: operand read/execute, memory/writeback, result.
// One instruction per cycle unless a valid result is stalled.
// Operands are bypassed from the two later stages, loads included.
// A stalled result freezes the whole pipeline; req_stall follows it.
// Reset clears the register file to zero by its valid bits; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mips_itype_execute_unit
   import mie_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [4:0]  req_command,
   input  logic [31:0] req_instruction_word,
   input  logic [31:0] req_current_pc,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_reg_write,
   output logic [4:0]  rsp_reg_index,
   output logic [31:0] rsp_reg_value,
   output logic        rsp_mem_write,
   output logic [31:0] rsp_mem_address,
   output logic        rsp_branch_taken,
   output logic [31:0] rsp_branch_target
);

   typedef enum logic [4:0] {
      CMD_ADDI  = 5'd0,
      CMD_ADDIU = 5'd1,
      CMD_ANDI  = 5'd2,
      CMD_ORI   = 5'd3,
      CMD_XORI  = 5'd4,
      CMD_SLTI  = 5'd5,
      CMD_SLTIU = 5'd6,
      CMD_BEQ   = 5'd7,
      CMD_BNE   = 5'd8,
      CMD_LB    = 5'd9,
      CMD_LBU   = 5'd10,
      CMD_LH    = 5'd11,
      CMD_LHU   = 5'd12,
      CMD_LW    = 5'd13,
      CMD_LUI   = 5'd14,
      CMD_SB    = 5'd15,
      CMD_SH    = 5'd16,
      CMD_SW    = 5'd17
   } cmd_type;

   localparam logic [1:0] SPAN_BYTE = 2'd0;
   localparam logic [1:0] SPAN_HALF = 2'd1;
   localparam logic [1:0] SPAN_WORD = 2'd3;

   logic move;

   // stage 1: operand read / execute
   logic              s1_valid_ff;
   logic [4:0]        s1_cmd_ff;
   logic [31:0]       s1_insn_ff;
   logic [31:0]       s1_pc_ff;
   logic [31:0]       rf_a;
   logic [31:0]       rf_b;
   logic [REG_AW-1:0] s1_rs;
   logic [REG_AW-1:0] s1_rt;
   logic [15:0]       s1_imm;
   logic [31:0]       s1_simm;
   logic [31:0]       s1_zimm;
   logic [31:0]       s1_simm4;
   logic [31:0]       s1_a;
   logic [31:0]       s1_b;
   logic [31:0]       s1_ea;
   logic [MEM_AW-1:0] s1_ea4;
   logic [31:0]       s1_target;
   logic [31:0]       s1_val;
   logic              s1_rw;
   logic              s1_mw;
   logic              s1_memop;
   logic              s1_taken;
   logic [1:0]        s1_span;
   dmem_req_type      dmem_req;
   rf_wr_type         rf_wr;

   // stage 2: memory / writeback
   logic              s2_valid_ff;
   logic [4:0]        s2_cmd_ff;
   logic [REG_AW-1:0] s2_rt_ff;
   logic [31:0]       s2_val_ff;
   logic              s2_rw_ff;
   logic              s2_mw_ff;
   logic              s2_memop_ff;
   logic [31:0]       s2_ea_ff;
   logic              s2_taken_ff;
   logic [31:0]       s2_target_ff;
   logic [7:0]        dmem_rd [4];
   logic [31:0]       s2_word;
   logic [63:0]       s2_dbl;
   logic [31:0]       s2_final;
   logic              s2_wr;

   // result register
   logic              rsp_valid_ff;
   logic              rsp_reg_write_ff;
   logic [4:0]        rsp_reg_index_ff;
   logic [31:0]       rsp_reg_value_ff;
   logic              rsp_mem_write_ff;
   logic [31:0]       rsp_mem_address_ff;
   logic              rsp_branch_taken_ff;
   logic [31:0]       rsp_branch_target_ff;
   logic              wb_wr;

   assign move      = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !move;

   // ---------------------------------------------------------------- stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (move) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         s1_cmd_ff  <= req_command;
         s1_insn_ff <= req_instruction_word;
         s1_pc_ff   <= req_current_pc;
      end
   end

   mie_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (move),
      .rd_idx_a  (req_instruction_word[RS_LSB +: REG_AW]),
      .rd_idx_b  (req_instruction_word[RT_LSB +: REG_AW]),
      .wr        (rf_wr),
      .rd_data_a (rf_a),
      .rd_data_b (rf_b)
   );

   assign s1_rs    = s1_insn_ff[RS_LSB +: REG_AW];
   assign s1_rt    = s1_insn_ff[RT_LSB +: REG_AW];
   assign s1_imm   = s1_insn_ff[15:0];
   assign s1_simm  = {{16{s1_imm[15]}}, s1_imm};
   assign s1_zimm  = {16'h0000, s1_imm};
   assign s1_simm4 = s1_simm + 32'd4;

   // bypass: stage 2 first, then the write made at the last advance
   assign s2_wr = s2_valid_ff && s2_rw_ff;
   assign wb_wr = rsp_valid_ff && rsp_reg_write_ff;

   always_comb begin
      if (s2_wr && s2_rt_ff == s1_rs) begin
         s1_a = s2_final;
      end else if (wb_wr && rsp_reg_index_ff == s1_rs) begin
         s1_a = rsp_reg_value_ff;
      end else begin
         s1_a = rf_a;
      end
      if (s2_wr && s2_rt_ff == s1_rt) begin
         s1_b = s2_final;
      end else if (wb_wr && rsp_reg_index_ff == s1_rt) begin
         s1_b = rsp_reg_value_ff;
      end else begin
         s1_b = rf_b;
      end
   end

   assign s1_ea     = s1_a + s1_simm;
   assign s1_ea4    = s1_a[MEM_AW-1:0] + s1_simm4[MEM_AW-1:0];
   assign s1_target = s1_pc_ff + 32'd4 + {s1_simm[29:0], 2'b00};

   always_comb begin
      s1_val   = '0;
      s1_rw    = 1'b0;
      s1_mw    = 1'b0;
      s1_memop = 1'b0;
      s1_taken = 1'b0;
      s1_span  = SPAN_BYTE;
      case (s1_cmd_ff)
         CMD_ADDI, CMD_ADDIU: begin
            s1_val = s1_ea;
            s1_rw  = 1'b1;
         end
         CMD_ANDI: begin
            s1_val = s1_a & s1_zimm;
            s1_rw  = 1'b1;
         end
         CMD_ORI: begin
            s1_val = s1_a | s1_zimm;
            s1_rw  = 1'b1;
         end
         CMD_XORI: begin
            s1_val = s1_a ^ s1_zimm;
            s1_rw  = 1'b1;
         end
         CMD_SLTI: begin
            s1_val = {31'b0, $signed(s1_a) < $signed(s1_simm)};
            s1_rw  = 1'b1;
         end
         CMD_SLTIU: begin
            s1_val = {31'b0, s1_a < s1_simm};
            s1_rw  = 1'b1;
         end
         CMD_BEQ: s1_taken = (s1_a == s1_b);
         CMD_BNE: s1_taken = (s1_a != s1_b);
         CMD_LB, CMD_LBU: begin
            s1_rw    = 1'b1;
            s1_memop = 1'b1;
         end
         CMD_LH, CMD_LHU: begin
            s1_rw    = 1'b1;
            s1_memop = 1'b1;
            s1_span  = SPAN_HALF;
         end
         CMD_LW: begin
            s1_rw    = 1'b1;
            s1_memop = 1'b1;
            s1_span  = SPAN_WORD;
         end
         CMD_LUI: begin
            s1_val = {s1_imm, 16'h0000};
            s1_rw  = 1'b1;
         end
         CMD_SB: begin
            s1_mw    = 1'b1;
            s1_memop = 1'b1;
         end
         CMD_SH: begin
            s1_mw    = 1'b1;
            s1_memop = 1'b1;
            s1_span  = SPAN_HALF;
         end
         CMD_SW: begin
            s1_mw    = 1'b1;
            s1_memop = 1'b1;
            s1_span  = SPAN_WORD;
         end
         default: begin
            s1_val = '0;
         end
      endcase
   end

   // bank j holds the byte of the access whose address is j modulo 4
   always_comb begin
      logic [1:0] lane;
      dmem_req.en = move;
      for (int j = 0; j < 4; j++) begin
         lane                 = 2'(j) - s1_ea[1:0];
         dmem_req.we[j]       = move && s1_valid_ff && s1_mw && (lane <= s1_span);
         dmem_req.wdata[j]    = s1_b[{lane, 3'b000} +: 8];
         dmem_req.row[j]      = (2'(j) < s1_ea[1:0]) ? s1_ea4[MEM_AW-1:2]
                                                     : s1_ea[MEM_AW-1:2];
      end
   end

   mie_dmem u_dmem (
      .clock   (clock),
      .req     (dmem_req),
      .rd_data (dmem_rd)
   );

   // ---------------------------------------------------------------- stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (move) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         s2_cmd_ff    <= s1_cmd_ff;
         s2_rt_ff     <= s1_rt;
         s2_val_ff    <= s1_val;
         s2_rw_ff     <= s1_rw;
         s2_mw_ff     <= s1_mw;
         s2_memop_ff  <= s1_memop;
         s2_ea_ff     <= s1_ea;
         s2_taken_ff  <= s1_taken;
         s2_target_ff <= s1_taken ? s1_target : '0;
      end
   end

   assign s2_dbl  = {dmem_rd[3], dmem_rd[2], dmem_rd[1], dmem_rd[0],
                     dmem_rd[3], dmem_rd[2], dmem_rd[1], dmem_rd[0]};
   assign s2_word = s2_dbl[{1'b0, s2_ea_ff[1:0], 3'b000} +: 32];

   always_comb begin
      case (s2_cmd_ff)
         CMD_LB:  s2_final = {{24{s2_word[7]}}, s2_word[7:0]};
         CMD_LBU: s2_final = {24'h000000, s2_word[7:0]};
         CMD_LH:  s2_final = {{16{s2_word[15]}}, s2_word[15:0]};
         CMD_LHU: s2_final = {16'h0000, s2_word[15:0]};
         CMD_LW:  s2_final = s2_word;
         default: s2_final = s2_val_ff;
      endcase
   end

   assign rf_wr.en   = move && s2_wr;
   assign rf_wr.idx  = s2_rt_ff;
   assign rf_wr.data = s2_final;

   // ---------------------------------------------------------------- result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (move) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         rsp_reg_write_ff     <= s2_rw_ff;
         rsp_reg_index_ff     <= s2_rw_ff ? s2_rt_ff : '0;
         rsp_reg_value_ff     <= s2_rw_ff ? s2_final : '0;
         rsp_mem_write_ff     <= s2_mw_ff;
         rsp_mem_address_ff   <= s2_memop_ff ? s2_ea_ff : '0;
         rsp_branch_taken_ff  <= s2_taken_ff;
         rsp_branch_target_ff <= s2_target_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_reg_write     = rsp_reg_write_ff;
   assign rsp_reg_index     = rsp_reg_index_ff;
   assign rsp_reg_value     = rsp_reg_value_ff;
   assign rsp_mem_write     = rsp_mem_write_ff;
   assign rsp_mem_address   = rsp_mem_address_ff;
   assign rsp_branch_taken  = rsp_branch_taken_ff;
   assign rsp_branch_target = rsp_branch_target_ff;

   // ---------------------------------------------------------------- checks
   `ASSERT_IMPLIES(a_store_no_regwrite, clock, reset,
      rsp_valid && rsp_mem_write, !rsp_reg_write, "store reports a register write")
   `ASSERT_IMPLIES(a_target_zero, clock, reset,
      rsp_valid && !rsp_branch_taken, rsp_branch_target == 32'd0,
      "branch target set without a taken branch")
   `ASSERT_IMPLIES(a_lane_pattern, clock, reset, dmem_req.we != 4'b0000,
      $countones(dmem_req.we) == 1 || $countones(dmem_req.we) == 2 ||
      $countones(dmem_req.we) == 4, "bad byte lane write pattern")
   `ASSERT_IMPLIES(a_write_on_advance, clock, reset, dmem_req.we != 4'b0000 || rf_wr.en,
      !req_stall, "state written while the pipeline is held")

endmodule

@@ bench/itype_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// itype_tb_pkg
// Operation codes of the I-type execute unit as seen by the bench.
// ----------------------------------------------------------------------------
package itype_tb_pkg;

   typedef enum logic [4:0] {
      OP_ADDI, OP_ADDIU, OP_ANDI, OP_ORI, OP_XORI, OP_SLTI, OP_SLTIU,
      OP_BEQ, OP_BNE, OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW, OP_LUI,
      OP_SB, OP_SH, OP_SW
   } itype_op_type;

   // codes above the last operation do nothing and give an all-zero result
   localparam logic [4:0] OP_UNUSED_MIN = 5'd18;
   localparam logic [4:0] OP_UNUSED_MAX = 5'd31;

endpackage

@@ bench/itype_exec_checker.sv @@
// ----------------------------------------------------------------------------
// itype_exec_checker
// Watches both channels of the execute unit. Every accepted instruction is
// executed against a private register file and byte memory; the retire
// record it yields is queued and compared field by field with the results
// as they leave the block, in order.
// ----------------------------------------------------------------------------
module itype_exec_checker
   import mie_pkg::*;
   import itype_tb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [4:0]  req_command,
   input  logic [31:0] req_instruction_word,
   input  logic [31:0] req_current_pc,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_reg_write,
   input  logic [4:0]  rsp_reg_index,
   input  logic [31:0] rsp_reg_value,
   input  logic        rsp_mem_write,
   input  logic [31:0] rsp_mem_address,
   input  logic        rsp_branch_taken,
   input  logic [31:0] rsp_branch_target,
   output int          mismatch_count,
   output int          retire_pending,
   output int          retired_count
);

   localparam int PRINT_CAP = 40;

   typedef struct packed {
      logic        reg_write;
      logic [4:0]  reg_index;
      logic [31:0] reg_value;
      logic        mem_write;
      logic [31:0] mem_address;
      logic        branch_taken;
      logic [31:0] branch_target;
   } retire_type;

   logic [31:0] gpr [REG_COUNT];
   logic [7:0]  dmem [int unsigned];
   retire_type  retire_q [$];
   int          mismatches;
   int          retired;

   function automatic int unsigned byte_slot(logic [31:0] ea, int k);
      return ((ea % MEM_BYTES) + k) % MEM_BYTES;
   endfunction

   function automatic logic [31:0] load_bytes(logic [31:0] ea, int n);
      logic [31:0] v;
      int unsigned slot;
      v = '0;
      for (int k = 0; k < n; k++) begin
         slot = byte_slot(ea, k);
         if (dmem.exists(slot))
            v[8*k +: 8] = dmem[slot];
      end
      return v;
   endfunction

   function automatic void store_bytes(logic [31:0] ea, int n, logic [31:0] v);
      for (int k = 0; k < n; k++)
         dmem[byte_slot(ea, k)] = v[8*k +: 8];
   endfunction

   function automatic retire_type execute_insn(logic [4:0] cmd, logic [31:0] word,
                                               logic [31:0] pc);
      retire_type  r;
      logic [4:0]  rs, rt;
      logic [15:0] imm;
      logic [31:0] simm, a, b, ea, val, m;
      logic        wr, memop;
      rs   = word[25:21];
      rt   = word[20:16];
      imm  = word[15:0];
      simm = {{16{imm[15]}}, imm};
      a    = gpr[rs];
      b    = gpr[rt];
      ea   = a + simm;
      r    = '0;
      val  = '0;
      wr   = 1'b0;
      memop = 1'b0;
      case (cmd)
         OP_ADDI, OP_ADDIU: begin val = a + simm; wr = 1'b1; end
         OP_ANDI:  begin val = a & {16'h0, imm}; wr = 1'b1; end
         OP_ORI:   begin val = a | {16'h0, imm}; wr = 1'b1; end
         OP_XORI:  begin val = a ^ {16'h0, imm}; wr = 1'b1; end
         OP_SLTI:  begin val = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0; wr = 1'b1; end
         OP_SLTIU: begin val = (a < simm) ? 32'd1 : 32'd0; wr = 1'b1; end
         OP_BEQ:   r.branch_taken = (a == b);
         OP_BNE:   r.branch_taken = (a != b);
         OP_LB: begin
            m = load_bytes(ea, 1);
            val = {{24{m[7]}}, m[7:0]}; wr = 1'b1; memop = 1'b1;
         end
         OP_LBU: begin val = load_bytes(ea, 1); wr = 1'b1; memop = 1'b1; end
         OP_LH: begin
            m = load_bytes(ea, 2);
            val = {{16{m[15]}}, m[15:0]}; wr = 1'b1; memop = 1'b1;
         end
         OP_LHU: begin val = load_bytes(ea, 2); wr = 1'b1; memop = 1'b1; end
         OP_LW:  begin val = load_bytes(ea, 4); wr = 1'b1; memop = 1'b1; end
         OP_LUI: begin val = {imm, 16'h0}; wr = 1'b1; end
         OP_SB: begin store_bytes(ea, 1, b); r.mem_write = 1'b1; memop = 1'b1; end
         OP_SH: begin store_bytes(ea, 2, b); r.mem_write = 1'b1; memop = 1'b1; end
         OP_SW: begin store_bytes(ea, 4, b); r.mem_write = 1'b1; memop = 1'b1; end
         default: ;
      endcase
      if (wr) begin
         gpr[rt]     = val;
         r.reg_write = 1'b1;
         r.reg_index = rt;
         r.reg_value = val;
      end
      if (memop)
         r.mem_address = ea;
      if (r.branch_taken)
         r.branch_target = pc + 32'd4 + (simm << 2);
      return r;
   endfunction

   task automatic note_fault(string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("checker: %s", msg);
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         note_fault($sformatf("result %0d: %s is %h, expected %h", retired, name, got, want));
   endtask

   always @(posedge clock) begin : monitor
      retire_type got, want;
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++)
            gpr[i] = '0;
         dmem.delete();
         retire_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_reg_write, rsp_reg_index, rsp_reg_value, rsp_mem_write,
                    rsp_mem_address, rsp_branch_taken, rsp_branch_target};
            if (retire_q.size() == 0) begin
               note_fault($sformatf("result transfer with nothing outstanding, value %h",
                                    rsp_reg_value));
            end else begin
               want = retire_q.pop_front();
               check_field("reg_write", 32'(got.reg_write), 32'(want.reg_write));
               check_field("reg_index", 32'(got.reg_index), 32'(want.reg_index));
               check_field("reg_value", got.reg_value, want.reg_value);
               check_field("mem_write", 32'(got.mem_write), 32'(want.mem_write));
               check_field("mem_address", got.mem_address, want.mem_address);
               check_field("branch_taken", 32'(got.branch_taken), 32'(want.branch_taken));
               check_field("branch_target", got.branch_target, want.branch_target);
               retired++;
            end
         end
         if (req_valid && !req_stall)
            retire_q.push_back(execute_insn(req_command, req_instruction_word,
                                            req_current_pc));
      end
      mismatch_count <= mismatches;
      retire_pending <= retire_q.size();
      retired_count  <= retired;
   end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the I-type execute unit. A directed opening covers
// overflow, zero-extended logic immediates, both compares, register zero,
// branch target wrap, address wrap, misaligned and sign-extending loads and
// unused codes; random instructions follow, with loads aimed only at bytes
// already stored. Both sides idle at random, the receiver holds off once for
// a long stretch and the sender drains the pipe between phases.
// ----------------------------------------------------------------------------
module tb;
   import mie_pkg::*;
   import itype_tb_pkg::*;

   localparam int RANDOM_ITEMS   = 1420;
   localparam int HOLD_AT        = 700;
   localparam int DRAIN_AT       = 1100;
   localparam int LONG_HOLD      = 200;
   localparam int WATCHDOG_LIMIT = 2000;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [4:0]  req_command = '0;
   logic [31:0] req_instruction_word = '0;
   logic [31:0] req_current_pc = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_reg_write;
   logic [4:0]  rsp_reg_index;
   logic [31:0] rsp_reg_value;
   logic        rsp_mem_write;
   logic [31:0] rsp_mem_address;
   logic        rsp_branch_taken;
   logic [31:0] rsp_branch_target;

   int mismatch_count, retire_pending, retired_count;
   int issued, n_directed, n_loads, n_stores, n_branches;
   int burst_left;
   int quiet_cycles;
   bit hold_active, hold_done;

   // what the sender knows of the block, just enough to aim loads at stored bytes
   bit          reg_known [REG_COUNT];
   logic [31:0] reg_shadow [REG_COUNT];
   bit          byte_written [MEM_BYTES];
   int unsigned store_bases [$];

   mips_itype_execute_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_command(req_command),
      .req_instruction_word(req_instruction_word), .req_current_pc(req_current_pc),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_reg_write(rsp_reg_write),
      .rsp_reg_index(rsp_reg_index), .rsp_reg_value(rsp_reg_value),
      .rsp_mem_write(rsp_mem_write), .rsp_mem_address(rsp_mem_address),
      .rsp_branch_taken(rsp_branch_taken), .rsp_branch_target(rsp_branch_target)
   );

   itype_exec_checker exec_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_command(req_command),
      .req_instruction_word(req_instruction_word), .req_current_pc(req_current_pc),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_reg_write(rsp_reg_write),
      .rsp_reg_index(rsp_reg_index), .rsp_reg_value(rsp_reg_value),
      .rsp_mem_write(rsp_mem_write), .rsp_mem_address(rsp_mem_address),
      .rsp_branch_taken(rsp_branch_taken), .rsp_branch_target(rsp_branch_target),
      .mismatch_count(mismatch_count), .retire_pending(retire_pending),
      .retired_count(retired_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic bit bytes_present(int unsigned addr, int n);
      for (int k = 0; k < n; k++)
         if (!byte_written[(addr + k) % MEM_BYTES])
            return 1'b0;
      return 1'b1;
   endfunction

   function automatic void note_issue(logic [4:0] cmd, logic [31:0] word);
      logic [4:0]  rs, rt;
      logic [15:0] imm;
      logic [31:0] simm, a;
      int unsigned ea;
      int          n;
      rs   = word[25:21];
      rt   = word[20:16];
      imm  = word[15:0];
      simm = {{16{imm[15]}}, imm};
      a    = reg_shadow[rs];
      n    = 0;
      case (cmd)
         OP_LUI: begin reg_known[rt] = 1'b1; reg_shadow[rt] = {imm, 16'h0}; end
         OP_ADDI, OP_ADDIU: begin
            reg_known[rt] = reg_known[rs]; reg_shadow[rt] = a + simm;
         end
         OP_ANDI: begin reg_known[rt] = reg_known[rs]; reg_shadow[rt] = a & {16'h0, imm}; end
         OP_ORI:  begin reg_known[rt] = reg_known[rs]; reg_shadow[rt] = a | {16'h0, imm}; end
         OP_XORI: begin reg_known[rt] = reg_known[rs]; reg_shadow[rt] = a ^ {16'h0, imm}; end
         OP_SLTI, OP_SLTIU: reg_known[rt] = 1'b0;
         OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW: begin reg_known[rt] = 1'b0; n_loads++; end
         OP_BEQ, OP_BNE: n_branches++;
         OP_SB: n = 1;
         OP_SH: n = 2;
         OP_SW: n = 4;
         default: ;
      endcase
      if (n != 0) begin
         n_stores++;
         if (reg_known[rs]) begin
            ea = (a + simm) % MEM_BYTES;
            for (int k = 0; k < n; k++)
               byte_written[(ea + k) % MEM_BYTES] = 1'b1;
            store_bases.push_back(ea);
         end
      end
   endfunction

   task automatic send_item(logic [4:0] cmd, logic [31:0] word, logic [31:0] pc);
      int gap, r;
      req_valid            <= 1'b1;
      req_command          <= cmd;
      req_instruction_word <= word;
      req_current_pc       <= pc;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      issued++;
      r = $urandom_range(0, 19);
      if (hold_active) begin
         gap = 0;
      end else if (burst_left > 0) begin
         gap = 0;
         burst_left--;
      end else if (r == 0) begin
         gap = 0;
         burst_left = $urandom_range(20, 60);
      end else if (r < 11) begin
         gap = 0;
      end else if (r < 18) begin
         gap = $urandom_range(1, 3);
      end else begin
         gap = $urandom_range(8, 30);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic issue(logic [4:0] cmd, logic [4:0] rs, logic [4:0] rt,
                        logic [15:0] imm, logic [31:0] pc);
      logic [31:0] word;
      word = {6'($urandom()), rs, rt, imm};
      note_issue(cmd, word);
      send_item(cmd, word, pc);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (retire_pending != 0);
   endtask

   task automatic issue_random();
      int          roll, pick, nb;
      logic [4:0]  cmd, rs, rt;
      logic [15:0] imm;
      int unsigned base, addr;
      int          known_idx [$];
      bit          ok;
      for (int i = 0; i < REG_COUNT; i++)
         if (reg_known[i])
            known_idx.push_back(i);
      roll = $urandom_range(0, 99);
      rs   = 5'($urandom());
      rt   = 5'($urandom());
      imm  = 16'($urandom());
      // a known base is needed first, and a stored byte before any load
      if (roll >= 42 && roll < 92 && known_idx.size() == 0)
         roll = 0;
      if (roll >= 62 && roll < 92 && store_bases.size() == 0)
         roll = 42;
      if (roll < 8) begin
         cmd = OP_LUI;
      end else if (roll < 30) begin
         cmd = 5'($urandom_range(OP_ADDI, OP_SLTIU));
      end else if (roll < 42) begin
         cmd = $urandom_range(0, 1) ? OP_BEQ : OP_BNE;
         if ($urandom_range(0, 2) == 0)
            rt = rs;
      end else if (roll < 62) begin
         pick = $urandom_range(0, 3);
         cmd  = (pick < 2) ? OP_SW : (pick == 2) ? OP_SH : OP_SB;
         if (known_idx.size() != 0 && $urandom_range(0, 3) != 0) begin
            rs   = 5'(known_idx[$urandom_range(0, known_idx.size() - 1)]);
            addr = ($urandom_range(0, 9) == 0) ? MEM_BYTES - 4 + $urandom_range(0, 3)
                                               : $urandom_range(0, 1023);
            imm  = 16'(addr - reg_shadow[rs]);
         end
      end else if (roll < 92) begin
         pick = $urandom_range(0, 4);
         cmd  = 5'(OP_LB + pick);
         nb   = (pick < 2) ? 1 : (pick < 4) ? 2 : 4;
         base = store_bases[$urandom_range(0, store_bases.size() - 1)];
         ok   = 1'b0;
         for (int t = 0; t < 3 && !ok; t++) begin
            addr = (base + $urandom_range(0, 3)) % MEM_BYTES;
            ok   = bytes_present(addr, nb);
         end
         if (!ok) begin
            addr = base;
            cmd  = OP_LBU;
         end
         rs  = 5'(known_idx[$urandom_range(0, known_idx.size() - 1)]);
         imm = 16'(addr - reg_shadow[rs]);
      end else begin
         cmd = 5'($urandom_range(OP_UNUSED_MIN, OP_UNUSED_MAX));
      end
      issue(cmd, rs, rt, imm, $urandom());
   endtask

   initial begin : receiver
      int go, stall_len, r;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (!hold_done && issued >= HOLD_AT) begin
            hold_active <= 1'b1;
            rsp_stall   <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_active <= 1'b0;
            hold_done = 1'b1;
         end
         r  = $urandom_range(0, 9);
         go = (r < 6) ? $urandom_range(1, 6) : (r < 9) ? $urandom_range(15, 60) : 1;
         r  = $urandom_range(0, 9);
         stall_len = (r < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
         rsp_stall <= 1'b0;
         repeat (go) @(posedge clock);
         rsp_stall <= 1'b1;
         repeat (stall_len) @(posedge clock);
      end
   end

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      issue(OP_LUI,   5'd0,  5'd1,  16'h7fff, $urandom());
      issue(OP_ORI,   5'd1,  5'd1,  16'hffff, $urandom());
      issue(OP_ADDI,  5'd1,  5'd2,  16'h0001, $urandom());   // signed overflow wraps
      issue(OP_ADDIU, 5'd2,  5'd3,  16'hffff, $urandom());
      issue(OP_ANDI,  5'd1,  5'd4,  16'h8000, $urandom());
      issue(OP_XORI,  5'd1,  5'd5,  16'hffff, $urandom());
      issue(OP_SLTI,  5'd2,  5'd6,  16'h0001, $urandom());
      issue(OP_SLTI,  5'd1,  5'd7,  16'hffff, $urandom());
      issue(OP_SLTIU, 5'd1,  5'd8,  16'hffff, $urandom());
      issue(OP_SLTIU, 5'd2,  5'd9,  16'h0000, $urandom());
      issue(OP_ADDIU, 5'd31, 5'd31, 16'h8000, $urandom());
      issue(OP_LUI,   5'd0,  5'd0,  16'h1234, $urandom());   // register zero is ordinary
      issue(OP_ADDIU, 5'd0,  5'd10, 16'h0000, $urandom());
      issue(OP_BEQ,   5'd1,  5'd3,  16'h0004, 32'hffff_fffc);
      issue(OP_BNE,   5'd1,  5'd3,  16'h8000, $urandom());
      issue(OP_BNE,   5'd1,  5'd2,  16'h8000, 32'h0000_0000);
      issue(OP_BEQ,   5'd1,  5'd2,  16'h7fff, $urandom());
      issue(OP_SW,    5'd0,  5'd2,  16'hfffe, $urandom());   // word straddles the top
      issue(OP_LW,    5'd0,  5'd12, 16'hfffe, $urandom());
      issue(OP_LB,    5'd0,  5'd13, 16'h0001, $urandom());
      issue(OP_LBU,   5'd0,  5'd14, 16'h0001, $urandom());
      issue(OP_SH,    5'd0,  5'd1,  16'h0010, $urandom());
      issue(OP_SB,    5'd0,  5'd1,  16'h0012, $urandom());
      issue(OP_LH,    5'd0,  5'd15, 16'h0011, $urandom());   // misaligned
      issue(OP_LHU,   5'd0,  5'd16, 16'h0010, $urandom());
      issue(OP_UNUSED_MIN, 5'($urandom()), 5'($urandom()), 16'($urandom()), $urandom());
      issue(OP_UNUSED_MAX, 5'($urandom()), 5'($urandom()), 16'($urandom()), $urandom());
      n_directed = issued;
      drain();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == DRAIN_AT)
            drain();
         issue_random();
      end
      drain();
      repeat (8) @(posedge clock);

      $display("tb: %0d instructions sent (%0d directed), %0d results compared",
               issued, n_directed, retired_count);
      $display("tb: %0d loads, %0d stores, %0d branches; one %0d-cycle receiver hold-off",
               n_loads, n_stores, n_branches, LONG_HOLD);
      if (mismatch_count == 0 && retire_pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/mie_pkg.sv
rtl/core/mie_regfile.sv
rtl/core/mie_dmem.sv
rtl/core/mips_itype_execute_unit.sv
bench/itype_tb_pkg.sv
bench/itype_exec_checker.sv
bench/tb.sv
